### sv/nseu_pkg.sv
package nseu_pkg;

  // table geometry
  localparam int NODES = 1024;
  localparam int DIM = 64;
  localparam int WORDS = NODES * DIM;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int DIM_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CNT_W = $clog2(DIM + 2);

  // field widths
  localparam int REQ_W = 2;
  localparam int NODE_W = 10;
  localparam int DIX_W = 6;
  localparam int VAL_W = 32;
  localparam int ALPHA_W = 25;
  localparam int SCORE_W = 25;

  // arithmetic widths
  localparam int FRAC = 24;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int TERM_W = 40;
  localparam int Z_W = TERM_W + DIM_W + 1;
  localparam int G_W = 27;

  // sigmoid table
  localparam int SIG_STEPS = 320;
  localparam int SIG_AW = $clog2(SIG_STEPS + 1);
  localparam int IDX_W = SIG_AW + 1;
  localparam int IDX_SHIFT = 19;
  localparam logic [31:0] EXP_STEP = 32'd4162825044;
  localparam logic [SCORE_W-1:0] ONE_Q = 25'h1000000;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 25'd419430;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRAIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  typedef logic signed [VAL_W-1:0] word_t;

  // clamp a 34-bit sum into a signed word
  function automatic word_t sat32(input logic signed [33:0] v);
    word_t r;
    if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

endpackage

### sv/nseu_ram.sv
module nseu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/negative_sampling_embedding_update.sv
// one beat at a time; the shared 33x33 multiplier does a dot pass and an update pass
//   over each row word (read, g*ctx, g*src)
// reset: synchronous active low; afterwards busy stays high
//   while the context table and accumulator are cleared and the sigmoid table built
// results are strobed on out_valid for one cycle; the receiver cannot stall
module negative_sampling_embedding_update (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [nseu_pkg::REQ_W-1:0]     in_req_type,
  input  logic [nseu_pkg::NODE_W-1:0]    in_node,
  input  logic [nseu_pkg::NODE_W-1:0]    in_target,
  input  logic                           in_label,
  input  logic                           in_last_of_node,
  input  logic [nseu_pkg::DIX_W-1:0]     in_dim_index,
  input  logic signed [nseu_pkg::VAL_W-1:0] in_load_value,
  input  logic                           cfg_wr_en,
  input  logic [nseu_pkg::ALPHA_W-1:0]   cfg_wr_data,
  output logic                           out_valid,
  output logic signed [nseu_pkg::VAL_W-1:0] out_read_value,
  output logic [nseu_pkg::SCORE_W-1:0]   out_score
);
  import nseu_pkg::*;

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_READ = 4'd2;
  localparam logic [3:0] ST_DOT = 4'd3;
  localparam logic [3:0] ST_SIG = 4'd4;
  localparam logic [3:0] ST_SIGW = 4'd5;
  localparam logic [3:0] ST_G = 4'd6;
  localparam logic [3:0] ST_U0 = 4'd7;
  localparam logic [3:0] ST_U1 = 4'd8;
  localparam logic [3:0] ST_U2 = 4'd9;
  localparam logic [3:0] ST_U3 = 4'd10;

  localparam logic [2:0] BLD_START = 3'd0;
  localparam logic [2:0] BLD_DIV = 3'd1;
  localparam logic [2:0] BLD_MUL = 3'd2;
  localparam logic [2:0] BLD_NEXT = 3'd3;
  localparam logic [2:0] BLD_DONE = 3'd4;

  localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(10 * (2 ** FRAC));

  // control state
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W:0]   clr_r, clr_nxt;
  logic [2:0]        bld_r, bld_nxt;
  logic [SIG_AW-1:0] t_r, t_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic              rv_r, rv_nxt;
  logic              pv_r, pv_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ALPHA_W-1:0] alpha_r;

  // payload state
  logic [32:0]       p_r, p_nxt;
  logic [34:0]       rem_r, rem_nxt;
  logic [24:0]       q_r, q_nxt;
  logic [ADDR_W-1:0] sbase_r, sbase_nxt;
  logic [ADDR_W-1:0] cbase_r, cbase_nxt;
  logic              label_r, label_nxt;
  logic              last_r, last_nxt;
  logic signed [Z_W-1:0] z_r, z_nxt;
  logic              hi_r, hi_nxt, lo_r, lo_nxt, neg_r, neg_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic signed [G_W-1:0] g_r, g_nxt;
  word_t             sw_r, sw_nxt, cw_r, cw_nxt, aw_r, aw_nxt, anew_r, anew_nxt;
  logic signed [PROD_W-1:0] prod_r;
  word_t             out_read_value_r, out_read_value_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // memory ports
  logic              src_we, ctx_we, acc_we, sig_we;
  logic [ADDR_W-1:0] src_waddr, src_raddr, ctx_waddr, ctx_raddr;
  logic [DIM_W-1:0]  acc_waddr, acc_raddr;
  word_t             src_wdata, ctx_wdata, acc_wdata;
  logic [VAL_W-1:0]  src_rdata, ctx_rdata, acc_rdata;
  logic [SIG_AW-1:0] sig_raddr;
  logic [SCORE_W-1:0] sig_rdata;

  // helpers
  logic              accept;
  logic              node_ok, target_ok, dix_ok;
  logic [ADDR_W-1:0] in_addr;
  logic [DIM_W-1:0]  idx, rd_idx;
  logic [33:0]       den;
  logic [56:0]       dvd;
  logic [34:0]       rem2;
  logic              ge;
  logic [63:0]       p_round;
  logic signed [Z_W-1:0] zsum;
  logic [IDX_W-1:0]  sidx, tval;
  logic [SCORE_W-1:0] s_w;
  logic signed [25:0] diff;
  logic signed [33:0] term;
  word_t             ctx_new;

  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign node_ok = (int'(in_node) < NODES);
  assign target_ok = (int'(in_target) < NODES);
  assign dix_ok = (int'(in_dim_index) < DIM);
  assign in_addr = ADDR_W'(int'(in_node) * DIM + int'(in_dim_index));
  assign idx = cnt_r[DIM_W-1:0];
  assign rd_idx = (state_r == ST_U3) ? idx + DIM_W'(1) : idx;

  assign mul_p = mul_a * mul_b;
  assign term = prod_r[FRAC+33:FRAC];

  // table builder arithmetic
  assign den = (34'd1 << 32) + {1'b0, p_r};
  assign dvd = (57'd1 << 56) + 57'(den >> 1);
  assign rem2 = {rem_r[33:0], dvd[bit_r]};
  assign ge = (rem2 >= {1'b0, den});
  assign p_round = prod_r[63:0] + 64'h8000_0000;

  // sigmoid index
  assign zsum = z_r + Z_LIM;
  assign sidx = zsum[IDX_SHIFT+IDX_W-1:IDX_SHIFT];
  assign tval = (sidx < IDX_W'(SIG_STEPS)) ? IDX_W'(SIG_STEPS) - sidx
                                           : sidx - IDX_W'(SIG_STEPS);

  always_comb begin
    if (hi_r) begin
      s_w = ONE_Q;
    end else if (lo_r) begin
      s_w = '0;
    end else if (neg_r) begin
      s_w = ONE_Q - sig_rdata;
    end else begin
      s_w = sig_rdata;
    end
  end

  assign diff = (label_r ? $signed(26'(ONE_Q)) : 26'sd0) - $signed({1'b0, s_w});
  assign ctx_new = sat32({{2{cw_r[VAL_W-1]}}, cw_r} + term);

  // sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    clr_nxt = clr_r;
    bld_nxt = bld_r;
    t_nxt = t_r;
    bit_nxt = bit_r;
    rv_nxt = 1'b0;
    pv_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    p_nxt = p_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    sbase_nxt = sbase_r;
    cbase_nxt = cbase_r;
    label_nxt = label_r;
    last_nxt = last_r;
    z_nxt = z_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    neg_nxt = neg_r;
    score_nxt = score_r;
    g_nxt = g_r;
    sw_nxt = sw_r;
    cw_nxt = cw_r;
    aw_nxt = aw_r;
    anew_nxt = anew_r;
    out_read_value_nxt = out_read_value_r;
    out_score_nxt = out_score_r;
    mul_a = '0;
    mul_b = '0;
    src_we = 1'b0;
    src_waddr = sbase_r + ADDR_W'(idx);
    src_wdata = sat32({{2{sw_r[VAL_W-1]}}, sw_r} + {{2{anew_r[VAL_W-1]}}, anew_r});
    src_raddr = sbase_r + ADDR_W'(rd_idx);
    ctx_we = 1'b0;
    ctx_waddr = cbase_r + ADDR_W'(idx);
    ctx_wdata = ctx_new;
    ctx_raddr = cbase_r + ADDR_W'(rd_idx);
    acc_we = 1'b0;
    acc_waddr = idx;
    acc_wdata = last_r ? '0 : anew_r;
    acc_raddr = rd_idx;
    sig_we = 1'b0;
    sig_raddr = tval[SIG_AW-1:0];

    unique case (state_r)
      ST_INIT: begin
        // clear sweep over the context table and accumulator
        if (clr_r != (ADDR_W + 1)'(WORDS)) begin
          ctx_we = 1'b1;
          ctx_waddr = clr_r[ADDR_W-1:0];
          ctx_wdata = '0;
          if (int'(clr_r) < DIM) begin
            acc_we = 1'b1;
            acc_waddr = clr_r[DIM_W-1:0];
            acc_wdata = '0;
          end
          clr_nxt = clr_r + 1'b1;
        end
        // sigmoid table builder, one restoring divide per entry
        unique case (bld_r)
          BLD_START: begin
            rem_nxt = 35'(dvd[56:25]);
            bit_nxt = 5'd24;
            q_nxt = '0;
            bld_nxt = BLD_DIV;
          end
          BLD_DIV: begin
            rem_nxt = ge ? rem2 - {1'b0, den} : rem2;
            q_nxt = {q_r[23:0], ge};
            if (bit_r == 5'd0) begin
              sig_we = 1'b1;
              bld_nxt = BLD_MUL;
            end else begin
              bit_nxt = bit_r - 5'd1;
            end
          end
          BLD_MUL: begin
            mul_a = {1'b0, p_r[31:0]};
            mul_b = {1'b0, EXP_STEP};
            bld_nxt = BLD_NEXT;
          end
          BLD_NEXT: begin
            p_nxt = p_r[32] ? {1'b0, EXP_STEP} : {1'b0, p_round[63:32]};
            if (t_r == SIG_AW'(SIG_STEPS)) begin
              bld_nxt = BLD_DONE;
            end else begin
              t_nxt = t_r + 1'b1;
              bld_nxt = BLD_START;
            end
          end
          BLD_DONE: begin
            if (clr_r == (ADDR_W + 1)'(WORDS)) begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            bld_nxt = BLD_DONE;
          end
        endcase
      end
      ST_IDLE: begin
        src_raddr = in_addr;
        if (start) begin
          out_read_value_nxt = '0;
          out_score_nxt = '0;
          sbase_nxt = ADDR_W'(int'(in_node) * DIM);
          cbase_nxt = ADDR_W'(int'(in_target) * DIM);
          label_nxt = in_label;
          last_nxt = in_last_of_node;
          cnt_nxt = '0;
          z_nxt = '0;
          if (in_req_type == REQ_LOAD) begin
            src_we = node_ok && dix_ok;
            src_waddr = in_addr;
            src_wdata = in_load_value;
            out_valid_nxt = 1'b1;
          end else if (in_req_type == REQ_READ && node_ok && dix_ok) begin
            state_nxt = ST_READ;
          end else if (in_req_type == REQ_TRAIN && node_ok && target_ok) begin
            state_nxt = ST_DOT;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        out_read_value_nxt = src_rdata;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DOT: begin
        // issue, multiply and accumulate overlap, with the read data and the product registered between them
        rv_nxt = (int'(cnt_r) < DIM);
        pv_nxt = rv_r;
        mul_a = {src_rdata[VAL_W-1], src_rdata};
        mul_b = {ctx_rdata[VAL_W-1], ctx_rdata};
        if (pv_r) begin
          z_nxt = z_r + Z_W'($signed(prod_r[FRAC+TERM_W-1:FRAC]));
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIM + 1)) begin
          state_nxt = ST_SIG;
        end
      end
      ST_SIG: begin
        hi_nxt = (z_r > Z_LIM);
        lo_nxt = (z_r < -Z_LIM);
        neg_nxt = (sidx < IDX_W'(SIG_STEPS));
        state_nxt = ST_SIGW;
      end
      ST_SIGW: begin
        score_nxt = s_w;
        mul_a = {8'd0, alpha_r};
        mul_b = {{(MUL_W - 26){diff[25]}}, diff};
        state_nxt = ST_G;
      end
      ST_G: begin
        g_nxt = prod_r[FRAC+G_W-1:FRAC];
        cnt_nxt = '0;
        state_nxt = ST_U0;
      end
      ST_U0: begin
        state_nxt = ST_U1;
      end
      ST_U1: begin
        sw_nxt = src_rdata;
        cw_nxt = ctx_rdata;
        aw_nxt = acc_rdata;
        mul_a = {{(MUL_W - G_W){g_r[G_W-1]}}, g_r};
        mul_b = {ctx_rdata[VAL_W-1], ctx_rdata};
        state_nxt = ST_U2;
      end
      ST_U2: begin
        anew_nxt = sat32({{2{aw_r[VAL_W-1]}}, aw_r} + term);
        mul_a = {{(MUL_W - G_W){g_r[G_W-1]}}, g_r};
        mul_b = {sw_r[VAL_W-1], sw_r};
        state_nxt = ST_U3;
      end
      ST_U3: begin
        // write back context, accumulator and on commit the source word
        ctx_we = 1'b1;
        acc_we = 1'b1;
        src_we = last_r;
        if (int'(cnt_r) == DIM - 1) begin
          out_score_nxt = score_r;
          out_read_value_nxt = '0;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_U1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r <= '0;
      clr_r <= '0;
      bld_r <= BLD_START;
      t_r <= '0;
      bit_r <= '0;
      rv_r <= 1'b0;
      pv_r <= 1'b0;
      out_valid_r <= 1'b0;
      alpha_r <= ALPHA_RESET;
      p_r <= 33'h1_0000_0000;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      clr_r <= clr_nxt;
      bld_r <= bld_nxt;
      t_r <= t_nxt;
      bit_r <= bit_nxt;
      rv_r <= rv_nxt;
      pv_r <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      p_r <= p_nxt;
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    sbase_r <= sbase_nxt;
    cbase_r <= cbase_nxt;
    label_r <= label_nxt;
    last_r <= last_nxt;
    z_r <= z_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    neg_r <= neg_nxt;
    score_r <= score_nxt;
    g_r <= g_nxt;
    sw_r <= sw_nxt;
    cw_r <= cw_nxt;
    aw_r <= aw_nxt;
    anew_r <= anew_nxt;
    prod_r <= mul_p;
    out_read_value_r <= out_read_value_nxt;
    out_score_r <= out_score_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_score = out_score_r;

  // source, context, accumulator and sigmoid memories
  nseu_ram #(.WIDTH(VAL_W), .DEPTH(WORDS)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  nseu_ram #(.WIDTH(VAL_W), .DEPTH(WORDS)) u_ctx_ram (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (ctx_waddr),
    .wdata (ctx_wdata),
    .raddr (ctx_raddr),
    .rdata (ctx_rdata)
  );

  nseu_ram #(.WIDTH(VAL_W), .DEPTH(DIM)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  nseu_ram #(.WIDTH(SCORE_W), .DEPTH(SIG_STEPS + 1)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (t_r),
    .wdata (q_nxt),
    .raddr (sig_raddr),
    .rdata (sig_rdata)
  );

`ifndef SYNTHESIS
  // a load beat answers in the next cycle
  a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == REQ_LOAD |=> out_valid)
    else $error("load beat gave no result");

  // a result is only shown once the sequencer is back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // sigmoid never exceeds one
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score <= ONE_Q)
    else $error("score above one");

  // the dot pass ends in the sigmoid lookup
  a_dot_to_sig: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DOT && cnt_r == CNT_W'(DIM + 1) |=> state_r == ST_SIG)
    else $error("dot pass did not finish");
`endif

endmodule

### sim/testbench.sv
module testbench;
  import nseu_pkg::*;

  localparam int HALF = 5;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int Q24 = 16777216;
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [SCORE_W-1:0]      score;
  } beat_t;

  // embedding predictor plus queue of expected beats
  class embed_scoreboard;
    int src_w[WORDS];
    int ctx_w[WORDS];
    int acc_w[DIM];
    bit written[WORDS];
    longint sig_lut[2*SIG_STEPS+1];
    logic [ALPHA_W-1:0] alpha;
    beat_t expected_beats[$];
    int errors;

    function new();
      longint unsigned p, den, s;
      p = 64'd1 << 32;
      for (int t = 0; t <= SIG_STEPS; t++) begin
        den = (64'd1 << 32) + p;
        s = ((64'd1 << 56) + den / 2) / den;
        sig_lut[SIG_STEPS+t] = longint'(s);
        sig_lut[SIG_STEPS-t] = longint'(Q24) - longint'(s);
        p = (p * 64'd4162825044 + (64'd1 << 31)) >> 32;
      end
      alpha = ALPHA_RESET;
      errors = 0;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function bit row_ready(int node);
      for (int d = 0; d < DIM; d++) if (!written[node*DIM+d]) return 0;
      return 1;
    endfunction

    // work out the beat that one accepted request produces
    function void note_request(logic [REQ_W-1:0] req, int node, int target, bit label,
                               bit last, int dix, int lv);
      beat_t b;
      longint z, sg, g;
      int sb, tb, idx;
      b.read_value = '0;
      b.score = '0;
      sb = node * DIM;
      tb = target * DIM;
      case (req)
        REQ_LOAD: begin
          src_w[sb+dix] = lv;
          written[sb+dix] = 1;
        end
        REQ_READ: b.read_value = src_w[sb+dix];
        REQ_TRAIN: begin
          z = 0;
          for (int d = 0; d < DIM; d++)
            z += (longint'(src_w[sb+d]) * longint'(ctx_w[tb+d])) >>> 24;
          if (z > 10 * longint'(Q24)) sg = Q24;
          else if (z < -10 * longint'(Q24)) sg = 0;
          else begin
            idx = int'((z + 10 * longint'(Q24)) >>> 19);
            if (idx < 0) idx = 0;
            if (idx > 2*SIG_STEPS) idx = 2*SIG_STEPS;
            sg = sig_lut[idx];
          end
          b.score = sg[SCORE_W-1:0];
          g = (longint'({39'd0, alpha}) * (longint'(label) * Q24 - sg)) >>> 24;
          for (int d = 0; d < DIM; d++)
            acc_w[d] = clamp32(longint'(acc_w[d]) + ((g * ctx_w[tb+d]) >>> 24));
          for (int d = 0; d < DIM; d++)
            ctx_w[tb+d] = clamp32(longint'(ctx_w[tb+d]) + ((g * src_w[sb+d]) >>> 24));
          if (last) begin
            for (int d = 0; d < DIM; d++) begin
              src_w[sb+d] = clamp32(longint'(src_w[sb+d]) + acc_w[d]);
              acc_w[d] = 0;
            end
          end
        end
        default: ;
      endcase
      expected_beats = {expected_beats, b};
    endfunction

    function void check_beat(logic signed [VAL_W-1:0] rv, logic [SCORE_W-1:0] sc);
      beat_t e;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat read_value=%0d score=%0d", rv, sc);
        errors++;
        return;
      end
      e = expected_beats.pop_front();
      if (rv !== e.read_value) begin
        $error("read_value expected %0d actual %0d", e.read_value, rv);
        errors++;
      end
      if (sc !== e.score) begin
        $error("score expected %0d actual %0d", e.score, sc);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [NODE_W-1:0] in_node = '0;
  logic [NODE_W-1:0] in_target = '0;
  logic in_label = 0;
  logic in_last_of_node = 0;
  logic [DIX_W-1:0] in_dim_index = '0;
  logic signed [VAL_W-1:0] in_load_value = '0;
  logic cfg_wr_en = 0;
  logic [ALPHA_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic signed [VAL_W-1:0] out_read_value;
  logic [SCORE_W-1:0] out_score;

  embed_scoreboard sb = new();
  int idle_pct = 0;
  int cycles = 0;
  int trained_nodes[$] = '{0, 1, 512, 1023};
  int loaded_words[$];

  negative_sampling_embedding_update u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_node(in_node), .in_target(in_target),
    .in_label(in_label), .in_last_of_node(in_last_of_node),
    .in_dim_index(in_dim_index), .in_load_value(in_load_value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_read_value(out_read_value), .out_score(out_score)
  );

  always #HALF clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result beat monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_beat(out_read_value, out_score);
  end

  // issue one request, return at the edge that accepts it
  task automatic send(logic [REQ_W-1:0] req, int node, int target, bit label, bit last,
                      int dix, int lv);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    in_req_type <= req;
    in_node <= node[NODE_W-1:0];
    in_target <= target[NODE_W-1:0];
    in_label <= label;
    in_last_of_node <= last;
    in_dim_index <= dix[DIX_W-1:0];
    in_load_value <= lv;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_request(req, node, target, label, last, dix, lv);
    if (req == REQ_LOAD) loaded_words = {loaded_words, node * DIM + dix};
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_beats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_alpha(logic [ALPHA_W-1:0] a);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= a;
    @(posedge clk);
    sb.alpha = a;
    cfg_wr_en <= 0;
  endtask

  function automatic int moderate_word();
    if ($urandom_range(9) == 0) return int'($urandom);
    return int'($urandom_range(0, 67108864)) - 33554432;
  endfunction

  task automatic random_request();
    int pick, node, w;
    pick = $urandom_range(99);
    if (pick < 15) begin
      node = ($urandom_range(1) == 0) ? trained_nodes[$urandom_range(3)]
                                      : int'($urandom_range(NODES - 1));
      send(REQ_LOAD, node, $urandom_range(NODES - 1), $urandom_range(1), $urandom_range(1),
           $urandom_range(DIM - 1), moderate_word());
    end else if (pick < 30) begin
      w = loaded_words[$urandom_range(loaded_words.size() - 1)];
      send(REQ_READ, w / DIM, $urandom_range(NODES - 1), $urandom_range(1),
           $urandom_range(1), w % DIM, int'($urandom));
    end else if (pick < 35) begin
      send(REQ_NOP, $urandom_range(NODES - 1), $urandom_range(NODES - 1), $urandom_range(1),
           $urandom_range(1), $urandom_range(DIM - 1), int'($urandom));
    end else begin
      node = trained_nodes[$urandom_range(3)];
      send(REQ_TRAIN, node,
           ($urandom_range(1) == 0) ? int'($urandom_range(7)) : int'($urandom_range(NODES - 1)),
           $urandom_range(1), $urandom_range(3) == 0, $urandom_range(DIM - 1), int'($urandom));
    end
  endtask

  initial begin
    logic [ALPHA_W-1:0] alphas[5];
    int phase_idle[5];
    alphas = '{ALPHA_RESET, 25'd16777216, 25'd0, 25'h1ffffff, 25'd0};
    phase_idle = '{0, 87, 16, 0, 87};
    alphas[4] = $urandom_range(0, 16777216);

    repeat (12) @(posedge clk);
    rst_n <= 1;
    do @(posedge clk); while (busy);

    // fill the rows that get trained
    foreach (trained_nodes[i])
      for (int d = 0; d < DIM; d++)
        send(REQ_LOAD, trained_nodes[i], 0, 0, 0, d, moderate_word());

    // directed: word extremes, every request kind, sigmoid clamps
    send(REQ_LOAD, 1023, 0, 0, 0, 63, 32'sh7fffffff);
    send(REQ_LOAD, 1023, 0, 0, 0, 0, 32'sh80000000);
    send(REQ_READ, 1023, 0, 0, 0, 63, 0);
    send(REQ_READ, 1023, 0, 0, 0, 0, 0);
    send(REQ_TRAIN, 0, 1023, 1, 0, 0, 0);
    send(REQ_TRAIN, 1, 0, 0, 1, 0, 0);
    send(REQ_NOP, 1023, 1023, 1, 1, 63, -1);
    write_alpha(25'd16777216);
    send(REQ_TRAIN, 1023, 1023, 1, 0, 0, 0);
    send(REQ_TRAIN, 1023, 1023, 1, 0, 0, 0);
    send(REQ_TRAIN, 1023, 1023, 0, 1, 0, 0);
    send(REQ_TRAIN, 0, 1023, 0, 1, 0, 0);
    send(REQ_READ, 1023, 0, 0, 0, 63, 0);
    send(REQ_READ, 0, 0, 0, 0, 5, 0);
    send(REQ_TRAIN, 512, 5, 1, 0, 0, 0);
    send(REQ_TRAIN, 1, 5, 0, 1, 0, 0);

    // random phases under different rates and idling
    for (int p = 0; p < 5; p++) begin
      write_alpha(alphas[p]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < 150; n++) random_request();
    end
    drain();

    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/nseu_pkg.sv
sv/nseu_ram.sv
sv/negative_sampling_embedding_update.sv
sim/testbench.sv
